>>> rtl/top1ac_pkg.sv
package top1ac_pkg;

    localparam int SCORE_BITS  = 16;
    localparam int LABEL_BITS  = 10;
    localparam int CLASS_BITS  = 11;
    localparam int ROW_BITS    = 17;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [CLASS_BITS-1:0] MAX_CLASSES = 11'd1024;
    localparam logic [ROW_BITS-1:0]   MAX_ROWS    = 17'd65536;

    localparam logic [CLASS_BITS-1:0] CLASS_COUNT_RESET = 11'd10;
    localparam logic [ROW_BITS-1:0]   ROW_COUNT_RESET   = 17'd1;

    localparam logic [CFG_IDX_BITS-1:0] REG_CLASS_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT   = 2'd1;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic [LABEL_BITS-1:0]        true_class;
    } in_item_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] correct_rows;
        logic [ROW_BITS-1:0] accuracy;
    } out_item_t;

endpackage

>>> rtl/top1_accuracy_counter.sv
// channel   direction  ports                                   payload
// s_        in         s_valid s_ready s_data                  in_item_t
// m_        out        m_valid m_ready m_data                  out_item_t
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// one score request per cycle; a row's last score that closes a batch starts
// a restoring divider on a 33-bit dividend (one quotient bit per cycle); s_ready stays low
// meanwhile and until the output register is loaded, which waits while it still holds a result
// aresetn is synchronous, active low; clears counters, registers go to defaults
// cfg_ready is always high
module top1_accuracy_counter
    import top1ac_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int DIVD_BITS = ROW_BITS + FRAC_BITS;
    localparam int CNT_BITS  = $clog2(DIVD_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVD_BITS - 1);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [CLASS_BITS-1:0] class_count_reg;
    logic [ROW_BITS-1:0]   row_count_reg;

    logic signed [SCORE_BITS-1:0] best_score_reg, best_score_next;
    logic [LABEL_BITS-1:0]        best_index_reg, best_index_next;
    logic [LABEL_BITS-1:0]        col_reg, col_next;
    logic [ROW_BITS-1:0]          row_reg, row_next;
    logic [ROW_BITS-1:0]          hit_reg, hit_next;

    logic [ROW_BITS-1:0]  divisor_reg, divisor_next;
    logic [ROW_BITS-1:0]  rem_reg, rem_next;
    logic [DIVD_BITS-1:0] quo_reg, quo_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [ROW_BITS-1:0]  correct_reg, correct_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic [CLASS_BITS-1:0] classes;
    logic [ROW_BITS-1:0]   rows;
    logic                  accept;
    logic                  take_best;
    logic                  last_col;
    logic                  batch_end;
    logic [ROW_BITS-1:0]   hit_row;
    logic [ROW_BITS:0]     rem_shift;
    logic                  ge;
    logic [ROW_BITS:0]     rem_sub;

    always_comb begin
        if (class_count_reg == '0) begin
            classes = CLASS_BITS'(1);
        end else if (class_count_reg > MAX_CLASSES) begin
            classes = MAX_CLASSES;
        end else begin
            classes = class_count_reg;
        end
        if (row_count_reg == '0) begin
            rows = ROW_BITS'(1);
        end else if (row_count_reg > MAX_ROWS) begin
            rows = MAX_ROWS;
        end else begin
            rows = row_count_reg;
        end
    end

    assign s_ready   = (state_reg == ST_RUN);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign take_best = (col_reg == '0) || (s_data.score > best_score_reg);
    assign last_col  = ({1'b0, col_reg} + CLASS_BITS'(1)) >= classes;
    assign batch_end = (row_reg + ROW_BITS'(1)) >= rows;

    // a label at or above the class count never hits
    always_comb begin
        logic [LABEL_BITS-1:0] idx;
        idx = take_best ? col_reg : best_index_reg;
        hit_row = hit_reg + ROW_BITS'((s_data.true_class == idx) &&
                                      ({1'b0, s_data.true_class} < classes));
    end

    assign rem_shift = {rem_reg, quo_reg[DIVD_BITS-1]};
    assign ge        = rem_shift >= {1'b0, divisor_reg};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};

    always_comb begin
        state_next      = state_reg;
        best_score_next = best_score_reg;
        best_index_next = best_index_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        hit_next        = hit_reg;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        correct_next    = correct_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    if (take_best) begin
                        best_score_next = s_data.score;
                        best_index_next = col_reg;
                    end
                    if (!last_col) begin
                        col_next = col_reg + LABEL_BITS'(1);
                    end else begin
                        col_next        = '0;
                        best_score_next = '0;
                        best_index_next = '0;
                        if (!batch_end) begin
                            row_next = row_reg + ROW_BITS'(1);
                            hit_next = hit_row;
                        end else begin
                            row_next     = '0;
                            hit_next     = '0;
                            correct_next = hit_row;
                            divisor_next = rows;
                            rem_next     = '0;
                            quo_next     = {hit_row, FRAC_BITS'(0)};
                            cnt_next     = '0;
                            state_next   = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                rem_next = ge ? rem_sub[ROW_BITS-1:0] : rem_shift[ROW_BITS-1:0];
                quo_next = {quo_reg[DIVD_BITS-2:0], ge};
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.correct_rows = correct_reg;
                    m_data_next.accuracy     = quo_reg[ROW_BITS-1:0];
                    state_next               = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_RUN;
            class_count_reg <= CLASS_COUNT_RESET;
            row_count_reg   <= ROW_COUNT_RESET;
            best_score_reg  <= '0;
            best_index_reg  <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            hit_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            best_score_reg <= best_score_next;
            best_index_reg <= best_index_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            hit_reg        <= hit_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_CLASS_COUNT: class_count_reg <= cfg_data[CLASS_BITS-1:0];
                    REG_ROW_COUNT:   row_count_reg   <= cfg_data[ROW_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        correct_reg <= correct_next;
        m_data_reg  <= m_data_next;
    end

endmodule

>>> bench/accuracy_checker.sv
module accuracy_checker
    import top1ac_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  in_item_t                 s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  out_item_t                m_data,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       fail_count,
    output int                       pending,
    output int                       tallies_seen
);

    logic [CLASS_BITS-1:0]        class_reg;
    logic [ROW_BITS-1:0]          row_reg;
    logic signed [SCORE_BITS-1:0] lead_score;
    logic [LABEL_BITS-1:0]        lead_col;
    int unsigned                  col_pos;
    int unsigned                  rows_done;
    int unsigned                  hits;
    out_item_t                    batch_tallies[$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        tallies_seen = 0;
    end

    // one score request into the running argmax and batch tally
    task automatic take_score(input in_item_t req);
        int unsigned       ncls;
        int unsigned       nrows;
        longint unsigned   ratio;
        out_item_t         tally;
        ncls  = (class_reg == 0) ? 1 : (class_reg > MAX_CLASSES) ? MAX_CLASSES : class_reg;
        nrows = (row_reg == 0) ? 1 : (row_reg > MAX_ROWS) ? MAX_ROWS : row_reg;
        if (col_pos == 0 || req.score > lead_score) begin
            lead_score = req.score;
            lead_col   = LABEL_BITS'(col_pos);
        end
        if (col_pos + 1 < ncls) begin
            col_pos++;
        end else begin
            if (req.true_class < ncls && req.true_class == lead_col)
                hits++;
            col_pos    = 0;
            lead_score = '0;
            lead_col   = '0;
            rows_done++;
            if (rows_done >= nrows) begin
                ratio              = (longint'(hits) << FRAC_BITS) / nrows;
                tally.correct_rows = ROW_BITS'(hits);
                tally.accuracy     = ROW_BITS'(ratio);
                batch_tallies.push_back(tally);
                rows_done = 0;
                hits      = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            class_reg  = CLASS_COUNT_RESET;
            row_reg    = ROW_COUNT_RESET;
            lead_score = '0;
            lead_col   = '0;
            col_pos    = 0;
            rows_done  = 0;
            hits       = 0;
            batch_tallies.delete();
        end else begin
            if (m_valid && m_ready) begin
                tallies_seen++;
                if (batch_tallies.size() == 0) begin
                    $error("unexpected batch result: correct_rows %0d accuracy %0d",
                           m_data.correct_rows, m_data.accuracy);
                    fail_count++;
                end else begin
                    want = batch_tallies.pop_front();
                    if (m_data.correct_rows !== want.correct_rows) begin
                        $error("correct_rows: expected %0d, got %0d",
                               want.correct_rows, m_data.correct_rows);
                        fail_count++;
                    end
                    if (m_data.accuracy !== want.accuracy) begin
                        $error("accuracy: expected %0d, got %0d",
                               want.accuracy, m_data.accuracy);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CLASS_COUNT: class_reg = cfg_data[CLASS_BITS-1:0];
                    REG_ROW_COUNT:   row_reg   = cfg_data[ROW_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                take_score(s_data);
        end
        pending = batch_tallies.size();
    end

endmodule

>>> bench/tb.sv
module tb;
    import top1ac_pkg::*;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    in_item_t                 s_data;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    out_item_t                m_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int fail_count;
    int pending;
    int tallies_seen;

    logic s_took   = 1'b0;
    logic cfg_took = 1'b0;

    int s_idle_pct  = 0;
    int m_stall_pct = 0;
    int eff_classes = CLASS_COUNT_RESET;
    int eff_rows    = ROW_COUNT_RESET;
    int n_scores    = 0;
    int n_writes    = 0;

    int s_idle_by_phase[4]  = '{0, 83, 0, 34};
    int m_stall_by_phase[4] = '{0, 0, 83, 34};

    top1_accuracy_counter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    accuracy_checker acc_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .tallies_seen (tallies_seen)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        s_took   <= s_valid && s_ready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= m_stall_pct);

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_score(input logic signed [SCORE_BITS-1:0] sc,
                              input logic [LABEL_BITS-1:0] lbl);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_valid           <= 1'b1;
        s_data.score      <= sc;
        s_data.true_class <= lbl;
        do @(negedge aclk); while (!s_took);
        n_scores++;
    endtask

    // drain outstanding results, then let the divider go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic configure(input int unsigned cls, input int unsigned rws);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_CLASS_COUNT;
        cfg_data  <= CFG_DATA_BITS'(cls);
        do @(negedge aclk); while (!cfg_took);
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= CFG_DATA_BITS'(rws);
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
        n_writes += 2;
        cls = cls & 32'h7FF;
        rws = rws & 32'h1FFFF;
        eff_classes = (cls == 0) ? 1 : (cls > MAX_CLASSES) ? MAX_CLASSES : cls;
        eff_rows    = (rws == 0) ? 1 : (rws > MAX_ROWS) ? MAX_ROWS : rws;
    endtask

    // peak column gets a near-max score so a matching label is likely a hit
    task automatic send_row(input int peak, input logic [LABEL_BITS-1:0] lbl);
        logic signed [SCORE_BITS-1:0] sc;
        for (int c = 0; c < eff_classes; c++) begin
            sc = (c == peak) ? SCORE_BITS'(32767 - $urandom_range(7)) : SCORE_BITS'($urandom);
            push_score(sc, (c == eff_classes - 1) ? lbl : LABEL_BITS'($urandom_range(1023)));
        end
    endtask

    task automatic run_random_batches();
        int unsigned cls;
        int unsigned rws;
        int          nb;
        int          peak;
        int          pick;
        logic [LABEL_BITS-1:0] lbl;
        if ($urandom_range(9) == 0)
            cls = $urandom_range(1) ? 0 : $urandom_range(11, 16);
        else
            cls = $urandom_range(1, 8);
        if ($urandom_range(9) == 0)
            rws = $urandom_range(1) ? 0 : $urandom_range(6, 10);
        else
            rws = $urandom_range(1, 5);
        configure(cls, rws);
        nb = $urandom_range(1, 2);
        repeat (nb * eff_rows) begin
            peak = $urandom_range(eff_classes - 1);
            pick = $urandom_range(9);
            if (pick < 6)
                lbl = LABEL_BITS'(peak);
            else if (pick < 8)
                lbl = LABEL_BITS'($urandom_range(eff_classes - 1));
            else
                lbl = LABEL_BITS'($urandom_range(1023));
            send_row(($urandom_range(4) == 0) ? -1 : peak, lbl);
        end
        // broken row left hanging into the next setting
        if ($urandom_range(6) == 0)
            repeat ($urandom_range(1, eff_classes))
                push_score(SCORE_BITS'($urandom), LABEL_BITS'($urandom_range(1023)));
    endtask

    initial begin
        int first_score;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CLASS_COUNT;
        cfg_data  = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: ten classes, one row per batch, max in last column
        for (int c = 0; c < 9; c++)
            push_score(-16'sd32768, LABEL_BITS'(c));
        push_score(16'sd32767, 10'd9);

        // zero registers act as one; out-of-range label misses
        configure(0, 0);
        push_score(16'sd0, 10'd0);
        push_score(16'sd0, 10'd1023);

        // ties keep the earliest column; label equal to class count misses
        configure(3, 2);
        push_score(16'sd5, 10'd0);
        push_score(16'sd5, 10'd0);
        push_score(16'sd5, 10'd0);
        push_score(-16'sd32768, 10'd0);
        push_score(-16'sd1, 10'd0);
        push_score(-16'sd32768, 10'd3);

        // shrink the row mid-row, then the batch mid-batch
        configure(4, 3);
        push_score(16'sd100, 10'd0);
        push_score(16'sd200, 10'd0);
        configure(2, 3);
        push_score(-16'sd5, 10'd1);
        push_score(16'sd7, 10'd5);
        push_score(16'sd7, 10'd0);
        configure(2, 1);
        push_score(16'sd1, 10'd0);
        push_score(16'sd2, 10'd1);

        // argmax column past a shrunk class count: matching label still misses
        configure(4, 1);
        push_score(16'sd1, 10'd0);
        push_score(16'sd2, 10'd0);
        configure(2, 1);
        push_score(16'sd9, 10'd2);

        // oversized class count saturates, then the row is cut short
        configure(2047, 1);
        repeat (30) push_score(SCORE_BITS'($urandom), LABEL_BITS'($urandom_range(1023)));
        configure(2, 1);
        push_score(16'sd0, 10'd0);

        // long batches past the row limit, closed early by a smaller row count
        configure(1, 65536);
        repeat (100) send_row(0, LABEL_BITS'($urandom_range(1)));
        configure(1, 131071);
        repeat (50) send_row(0, LABEL_BITS'($urandom_range(1)));
        configure(1, 4);
        send_row(0, 10'd0);

        for (int ph = 0; ph < 4; ph++) begin
            s_idle_pct  = s_idle_by_phase[ph];
            m_stall_pct = m_stall_by_phase[ph];
            first_score = n_scores;
            while (n_scores - first_score < 90)
                run_random_batches();
        end

        m_stall_pct = 0;
        settle();
        $display("covered %0d score requests, %0d register writes, %0d batch results",
                 n_scores, n_writes, tallies_seen);
        $display("ran four handshake phases with sender gaps and result stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
